// ===== sv/rts_pkg.sv =====
// Package for the response token scanner: payload structs, codes and the
// per-token character tables with the shared matcher step.
// No dependencies.
package rts_pkg;

  // Opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Outcomes
  localparam logic [1:0] OUT_PASS    = 2'd0;
  localparam logic [1:0] OUT_FAIL    = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT = 2'd2;

  // Token codes
  localparam logic [2:0] TOK_NONE    = 3'd0;
  localparam logic [2:0] TOK_CONNECT = 3'd1;
  localparam logic [2:0] TOK_CLOSED  = 3'd2;
  localparam logic [2:0] TOK_ERROR   = 3'd3;
  localparam logic [2:0] TOK_FAIL    = 3'd4;
  localparam logic [2:0] TOK_OK      = 3'd5;

  // Configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MODE    = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  // Last position of each token
  localparam logic [2:0] CONNECT_LAST = 3'd6;
  localparam logic [2:0] CLOSED_LAST  = 3'd5;
  localparam logic [2:0] ERROR_LAST   = 3'd4;
  localparam logic [2:0] FAIL_LAST    = 3'd3;
  localparam logic [2:0] OK_LAST      = 3'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [2:0] token_seen;
  } out_item_t;

  typedef struct packed {
    logic       done;
    logic [2:0] nxt;
  } match_t;

  // Out-of-range positions return the first letter, matching a restart at zero.
  function automatic logic [7:0] connect_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1: c = "O";
      3'd2: c = "N";
      3'd3: c = "N";
      3'd4: c = "E";
      3'd5: c = "C";
      3'd6: c = "T";
      default: c = "C";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] closed_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1: c = "L";
      3'd2: c = "O";
      3'd3: c = "S";
      3'd4: c = "E";
      3'd5: c = "D";
      default: c = "C";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] error_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1: c = "R";
      3'd2: c = "R";
      3'd3: c = "O";
      3'd4: c = "R";
      default: c = "E";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fail_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1: c = "a";
      3'd2: c = "i";
      3'd3: c = "l";
      default: c = "F";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ok_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd1: c = "K";
      default: c = "O";
    endcase
    return c;
  endfunction

  // One matcher step: ch_p is the token letter at p (first letter when p is
  // out of range), ch0 the first letter.
  function automatic match_t match_step(logic [2:0] p, logic [2:0] last,
                                        logic [7:0] c, logic [7:0] ch_p,
                                        logic [7:0] ch0);
    match_t     m;
    logic [2:0] pe;
    pe = (p > last) ? 3'd0 : p;
    m.done = 1'b0;
    if (c == ch_p) begin
      if (pe == last) begin
        m.done = 1'b1;
        m.nxt  = 3'd0;
      end else begin
        m.nxt = pe + 3'd1;
      end
    end else begin
      m.nxt = (c == ch0) ? 3'd1 : 3'd0;
    end
    return m;
  endfunction

endpackage

// ===== sv/response_token_scanner.sv =====
// Response token scanner top level: input register, matcher and timeout
// logic, result register. Depends on rts_pkg.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_valid / in_ready   | rts_pkg::in_item_t  (opcode, rx_byte)
//   out_    | out | out_valid / out_ready | rts_pkg::out_item_t (outcome, token_seen)
//   cfg_    | in  | cfg_we               | cfg_index, cfg_wdata (16 bits)
//
// One item per cycle unless out_ready stalls; a verdict passes through the
// input register and then the result register. Both hold one item, so a stall
// on out_ready backs up through in_ready only once both are full.
// rst_n (synchronous) idles the scan, clears the matchers and elapsed count
// and loads timeout_ticks 1500, scan_mode 0.
module response_token_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rts_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import rts_pkg::*;

  logic        limit_zero;
  logic [15:0] timeout_ticks_r;
  logic        scan_mode_r;

  logic        s1_valid_r;
  in_item_t    s1_data_r;

  logic        active_r,  active_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [2:0]  connect_r, connect_nxt;
  logic [2:0]  closed_r,  closed_nxt;
  logic [2:0]  error_r,   error_nxt;
  logic [1:0]  fail_r,    fail_nxt;
  logic        ok_r,      ok_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        advance;
  logic        res_valid;
  out_item_t   res;
  logic [15:0] elapsed_inc;
  logic [7:0]  c;
  match_t      m_connect, m_closed, m_error, m_fail, m_ok;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign limit_zero = (timeout_ticks_r == 16'd0);
  assign c = s1_data_r.rx_byte;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 16'd1;

  assign m_connect = match_step(connect_r, CONNECT_LAST, c, connect_char(connect_r),
                                connect_char(3'd0));
  assign m_closed  = match_step(closed_r, CLOSED_LAST, c, closed_char(closed_r),
                                closed_char(3'd0));
  assign m_error   = match_step(error_r, ERROR_LAST, c, error_char(error_r),
                                error_char(3'd0));
  assign m_fail    = match_step({1'b0, fail_r}, FAIL_LAST, c, fail_char({1'b0, fail_r}),
                                fail_char(3'd0));
  assign m_ok      = match_step({2'b00, ok_r}, OK_LAST, c, ok_char({2'b00, ok_r}),
                                ok_char(3'd0));

  always_comb begin
    active_nxt  = active_r;
    elapsed_nxt = elapsed_r;
    connect_nxt = connect_r;
    closed_nxt  = closed_r;
    error_nxt   = error_r;
    fail_nxt    = fail_r;
    ok_nxt      = ok_r;
    res_valid   = 1'b0;
    res.outcome    = OUT_PASS;
    res.token_seen = TOK_NONE;
    if (s1_valid_r) begin
      case (s1_data_r.opcode)
        OP_START: begin
          active_nxt  = 1'b1;
          elapsed_nxt = 16'd0;
          connect_nxt = 3'd0;
          closed_nxt  = 3'd0;
          error_nxt   = 3'd0;
          fail_nxt    = 2'd0;
          ok_nxt      = 1'b0;
          if (limit_zero) begin
            active_nxt     = 1'b0;
            res_valid      = 1'b1;
            res.outcome    = OUT_TIMEOUT;
          end
        end
        OP_TICK: begin
          if (active_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= timeout_ticks_r) begin
              active_nxt  = 1'b0;
              res_valid   = 1'b1;
              res.outcome = OUT_TIMEOUT;
            end
          end
        end
        OP_BYTE: begin
          if (active_r) begin
            if (scan_mode_r) begin
              ok_nxt = m_ok.nxt[0];
              if (m_ok.done) begin
                active_nxt     = 1'b0;
                res_valid      = 1'b1;
                res.token_seen = TOK_OK;
              end
            end else begin
              // Matchers after the completing one hold, as the scan closes.
              connect_nxt = m_connect.nxt;
              if (m_connect.done) begin
                active_nxt     = 1'b0;
                res_valid      = 1'b1;
                res.token_seen = TOK_CONNECT;
              end else begin
                closed_nxt = m_closed.nxt;
                if (m_closed.done) begin
                  active_nxt     = 1'b0;
                  res_valid      = 1'b1;
                  res.token_seen = TOK_CLOSED;
                end else begin
                  error_nxt = m_error.nxt;
                  if (m_error.done) begin
                    active_nxt     = 1'b0;
                    res_valid      = 1'b1;
                    res.outcome    = OUT_FAIL;
                    res.token_seen = TOK_ERROR;
                  end else begin
                    fail_nxt = m_fail.nxt[1:0];
                    if (m_fail.done) begin
                      active_nxt     = 1'b0;
                      res_valid      = 1'b1;
                      res.outcome    = OUT_FAIL;
                      res.token_seen = TOK_FAIL;
                    end
                  end
                end
              end
            end
          end
        end
        default: begin
          // unused opcode: drop
        end
      endcase
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= TIMEOUT_RESET;
      scan_mode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_ticks_r <= cfg_wdata;
        REG_MODE:    scan_mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Scan state advances as the input register's item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      elapsed_r <= 16'd0;
      connect_r <= 3'd0;
      closed_r  <= 3'd0;
      error_r   <= 3'd0;
      fail_r    <= 2'd0;
      ok_r      <= 1'b0;
    end else if (advance) begin
      active_r  <= active_nxt;
      elapsed_r <= elapsed_nxt;
      connect_r <= connect_nxt;
      closed_r  <= closed_nxt;
      error_r   <= error_nxt;
      fail_r    <= fail_nxt;
      ok_r      <= ok_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  a_verdict_closes_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && res_valid) |=> !active_r)
    else $error("scan still open after a verdict");

  a_timeout_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.outcome == OUT_TIMEOUT) |-> out_data_r.token_seen == TOK_NONE)
    else $error("timeout verdict carries a token");

  a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input register changed while stalled");

  a_progress_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (connect_r <= CONNECT_LAST) && (closed_r <= CLOSED_LAST) && (error_r <= ERROR_LAST))
    else $error("matcher progress past token end");

endmodule

// ===== tb/tb_response_token_scanner.sv =====
// Self-checking testbench for response_token_scanner: directed token, timeout,
// configuration and backpressure cases, then random scans, checked against a
// local model. Depends on rts_pkg and response_token_scanner.
`timescale 1ns / 100ps

module tb_response_token_scanner;
  import rts_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEM_BUDGET  = 2000;
  localparam int PHASE_ITEMS  = 50;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [15:0] cfg_wdata;

  response_token_scanner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Scanner model state
  logic [15:0] model_limit;
  logic        model_mode;
  logic        model_open;
  logic [15:0] model_elapsed;
  logic [2:0]  prog_connect;
  logic [2:0]  prog_closed;
  logic [2:0]  prog_error;
  logic [1:0]  prog_fail;
  logic        prog_ok;

  out_item_t verdict_q[$];
  out_item_t want;
  int        fail_count;
  int        cycle_count;
  int        items_sent;
  bit        no_idle;
  bit        hold_req;
  int        ready_stall;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** response_token_scanner: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Advance one token matcher on byte c; hit is set when the token completes.
  function automatic logic [2:0] match_advance(input logic [2:0] prog, input string tok,
                                               input logic [7:0] c, output bit hit);
    int pos;
    hit = 1'b0;
    pos = prog;
    if (pos >= tok.len()) begin
      pos = 0;
    end
    if (c == tok[pos]) begin
      pos = pos + 1;
      if (pos == tok.len()) begin
        hit = 1'b1;
        return 3'd0;
      end
      return pos[2:0];
    end
    return (c == tok[0]) ? 3'd1 : 3'd0;
  endfunction

  function automatic void clear_matchers();
    prog_connect = '0;
    prog_closed  = '0;
    prog_error   = '0;
    prog_fail    = '0;
    prog_ok      = '0;
  endfunction

  function automatic void push_verdict(input logic [1:0] outcome, input logic [2:0] tok);
    out_item_t v;
    v.outcome    = outcome;
    v.token_seen = tok;
    verdict_q.push_back(v);
    model_open = 1'b0;
  endfunction

  // Update the model for one transferred item; returns 1 if the block acts on it.
  function automatic bit predict_verdict(input in_item_t it);
    bit          hit;
    logic [2:0]  p;
    if (it.opcode == OP_START) begin
      clear_matchers();
      model_elapsed = '0;
      model_open    = 1'b1;
      if (model_limit == 16'd0) begin
        push_verdict(OUT_TIMEOUT, TOK_NONE);
      end
      return 1'b1;
    end
    if (!model_open || (it.opcode != OP_TICK && it.opcode != OP_BYTE)) begin
      return 1'b0;
    end
    if (it.opcode == OP_TICK) begin
      if (model_elapsed != ELAPSED_MAX) begin
        model_elapsed = model_elapsed + 16'd1;
      end
      if (model_elapsed >= model_limit) begin
        push_verdict(OUT_TIMEOUT, TOK_NONE);
      end
      return 1'b1;
    end
    if (model_mode) begin
      p = match_advance({2'b00, prog_ok}, "OK", it.rx_byte, hit);
      prog_ok = p[0];
      if (hit) begin
        push_verdict(OUT_PASS, TOK_OK);
      end
      return 1'b1;
    end
    // Stop at the first completed token, as the block does.
    prog_connect = match_advance(prog_connect, "CONNECT", it.rx_byte, hit);
    if (hit) begin
      push_verdict(OUT_PASS, TOK_CONNECT);
      return 1'b1;
    end
    prog_closed = match_advance(prog_closed, "CLOSED", it.rx_byte, hit);
    if (hit) begin
      push_verdict(OUT_PASS, TOK_CLOSED);
      return 1'b1;
    end
    prog_error = match_advance(prog_error, "ERROR", it.rx_byte, hit);
    if (hit) begin
      push_verdict(OUT_FAIL, TOK_ERROR);
      return 1'b1;
    end
    p = match_advance({1'b0, prog_fail}, "Fail", it.rx_byte, hit);
    prog_fail = p[1:0];
    if (hit) begin
      push_verdict(OUT_FAIL, TOK_FAIL);
    end
    return 1'b1;
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    void'(predict_verdict(it));
    items_sent++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] b);
    in_item_t it;
    it.opcode  = op;
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_op(OP_BYTE, s[i]);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_op(OP_TICK, 8'($urandom));
  endtask

  // Drop valid and let every pending verdict and in-flight item clear.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIMEOUT) begin
      model_limit = val;
    end else begin
      model_mode = val[0];
    end
  endtask

  task automatic configure(input logic [15:0] limit, input logic mode);
    wait_idle();
    write_reg(REG_TIMEOUT, limit);
    write_reg(REG_MODE, {15'($urandom), mode});
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with none expected: outcome %0d token_seen %0d",
               out_data.outcome, out_data.token_seen);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_data.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, out_data.outcome);
          fail_count++;
        end
        if (out_data.token_seen !== want.token_seen) begin
          $error("token_seen: expected %0d, got %0d", want.token_seen, out_data.token_seen);
          fail_count++;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready   = 1'b0;
    ready_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (ready_stall > 0) begin
        out_ready <= 1'b0;
        ready_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          ready_stall = pick_gap();
        end
      end
    end
  end

  // Idle items are ignored; reset limit of 1500 ticks applies.
  task automatic test_idle_and_defaults();
    send_op(OP_TICK, 8'h00);
    send_op(OP_BYTE, "C");
    send_op(2'd3, 8'hFF);
    send_op(OP_START, 8'h00);
    send_word("CONNECT");
    no_idle = 1'b1;
    send_op(OP_START, 8'hFF);
    send_ticks(1500);
    no_idle = 1'b0;
  endtask

  task automatic test_response_tokens();
    send_op(OP_START, 8'h5A);
    send_word("CLOSED");
    send_op(OP_START, 8'h00);
    send_op(OP_BYTE, 8'h00);
    send_op(OP_BYTE, 8'hFF);
    send_word("ERRERROR");
    send_op(OP_START, 8'h00);
    send_word("FaFail");
    send_op(OP_START, 8'h00);
    send_word("CCONNECT");
    // Restart mid-token, and an unused opcode inside a token
    send_op(OP_START, 8'h00);
    send_word("CONN");
    send_op(OP_START, 8'h00);
    send_word("CONN");
    send_op(2'd3, "E");
    send_word("ECT");
  endtask

  task automatic test_init_token();
    configure(TIMEOUT_RESET, 1'b1);
    send_op(OP_START, 8'h00);
    send_word("CONNECT");
    send_word("OOK");
  endtask

  task automatic test_zero_limit();
    configure(16'd0, 1'b0);
    send_op(OP_START, 8'h00);
    send_op(OP_TICK, 8'h00);
    send_word("ERROR");
  endtask

  task automatic test_midscan_changes();
    configure(16'd50, 1'b0);
    send_op(OP_START, 8'h00);
    send_ticks(10);
    wait_idle();
    write_reg(REG_TIMEOUT, 16'd5);
    send_op(OP_TICK, 8'h00);
    send_op(OP_START, 8'h00);
    send_word("CONN");
    wait_idle();
    write_reg(REG_MODE, 16'h0001);
    send_word("OX");
    wait_idle();
    write_reg(REG_MODE, 16'hFFFE);
    send_word("ECT");
  endtask

  task automatic test_max_limit();
    configure(16'hFFFF, 1'b0);
    no_idle = 1'b1;
    send_op(OP_START, 8'h00);
    send_ticks(20);
    no_idle = 1'b0;
    send_word("Fail");
    configure(16'd1, 1'b0);
    send_op(OP_START, 8'h00);
    send_op(OP_TICK, 8'h00);
  endtask

  // Hold the result side while starts keep arriving, so the input backs up.
  task automatic test_backpressure();
    configure(16'd0, 1'b0);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (20) send_op(OP_START, 8'($urandom));
    no_idle = 1'b0;
    wait_idle();
  endtask

  function automatic string pick_token();
    int r;
    r = $urandom_range(0, 4);
    if (model_mode && $urandom_range(0, 9) < 6) begin
      return "OK";
    end
    case (r)
      0: return "CONNECT";
      1: return "CLOSED";
      2: return "ERROR";
      3: return "Fail";
      default: return "OK";
    endcase
  endfunction

  task automatic random_scan();
    string s;
    string letters;
    int    r;
    letters = "CONNECTLOSDERFailK";
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_op(2'($urandom), 8'($urandom));
    end
    send_op(OP_START, 8'($urandom));
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_word(pick_token());
      end else if (r < 45) begin
        s = pick_token();
        send_word(s.substr(0, $urandom_range(0, s.len() - 2)));
      end else if (r < 60) begin
        send_ticks($urandom_range(1, 6));
      end else if (r < 70) begin
        send_op(OP_BYTE, 8'($urandom));
      end else if (r < 75) begin
        send_op(2'($urandom), 8'($urandom));
      end else if (r < 90) begin
        send_op(OP_BYTE, letters[$urandom_range(0, letters.len() - 1)]);
      end else begin
        send_op(OP_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] limit;
    int          r;
    int          phase_end;
    while (items_sent < ITEM_BUDGET) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        limit = 16'd0;
      end else if (r == 1) begin
        limit = 16'hFFFF;
      end else if (r == 2) begin
        limit = 16'd1;
      end else begin
        limit = 16'($urandom_range(2, 40));
      end
      configure(limit, 1'($urandom));
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_BUDGET) begin
        random_scan();
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_TIMEOUT;
    cfg_wdata     = '0;
    fail_count    = 0;
    cycle_count   = 0;
    items_sent    = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    model_limit   = TIMEOUT_RESET;
    model_mode    = 1'b0;
    model_open    = 1'b0;
    model_elapsed = '0;
    clear_matchers();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_defaults();
    test_response_tokens();
    test_init_token();
    test_zero_limit();
    test_midscan_changes();
    test_max_limit();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (fail_count == 0) begin
      $display("** response_token_scanner: PASSED **");
    end else begin
      $display("** response_token_scanner: FAILED **");
    end
    $finish;
  end

endmodule
